### design/sdiv_pkg.sv
// Shared types and constants for the signed saturating divider.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package sdiv_pkg;

  // Operand and quotient width
  localparam int unsigned DATA_WIDTH = 32;
  // Width of the iteration counter (counts DATA_WIDTH-1 down to 0)
  localparam int unsigned CNT_WIDTH  = $clog2(DATA_WIDTH);

  // Saturation limits of the signed range
  localparam logic [DATA_WIDTH-1:0] INT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } sdiv_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture operand magnitudes and signs
    logic step;    // run one shift-subtract iteration
    logic finish;  // apply sign and saturation into the output register
  } sdiv_cmd_t;

endpackage

`default_nettype wire

### design/sdiv_dpath.sv
// Datapath of the signed saturating divider: operand magnitudes, radix-2
// restoring division registers, sign fix-up and the output word register.
// Depends on sdiv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdiv_dpath
  import sdiv_pkg::*;
(
  input  wire  logic                  clk_i,
  input  wire  sdiv_cmd_t             cmd_i,
  input  wire  logic [DATA_WIDTH-1:0] numerator_i,
  input  wire  logic [DATA_WIDTH-1:0] denominator_i,
  output logic [DATA_WIDTH-1:0]       quotient_o
);

  logic [DATA_WIDTH-1:0] nmag;
  logic [DATA_WIDTH-1:0] dmag;

  // Dividend shifts out of the top while quotient bits shift in at the bottom
  logic [DATA_WIDTH-1:0] quo_q, quo_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] dmag_q, dmag_d;
  logic                  neg_q, neg_d;
  logic                  dzero_q, dzero_d;
  logic [DATA_WIDTH-1:0] res_q, res_d;

  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] qclamp;

  // Take magnitudes of the incoming operands
  assign nmag = numerator_i[DATA_WIDTH-1]   ? (~numerator_i + 1'b1)   : numerator_i;
  assign dmag = denominator_i[DATA_WIDTH-1] ? (~denominator_i + 1'b1) : denominator_i;

  // One trial subtraction per iteration
  assign rem_sh = {rem_q, quo_q[DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dmag_q};

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dmag_d  = dmag_q;
    neg_d   = neg_q;
    dzero_d = dzero_q;
    if (cmd_i.load) begin
      quo_d   = nmag;
      rem_d   = '0;
      dmag_d  = dmag;
      neg_d   = numerator_i[DATA_WIDTH-1] ^ denominator_i[DATA_WIDTH-1];
      dzero_d = (denominator_i == '0);
    end else if (cmd_i.step) begin
      if (!diff[DATA_WIDTH]) begin
        rem_d = diff[DATA_WIDTH-1:0];
        quo_d = {quo_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DATA_WIDTH-1:0];
        quo_d = {quo_q[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  // Apply sign and clamp to the signed range; zero divisor gives the positive limit
  always_comb begin
    qclamp = quo_q;
    res_d  = res_q;
    if (neg_q) begin
      if (quo_q > INT_MIN) begin
        qclamp = INT_MIN;
      end
    end else begin
      if (quo_q > INT_MAX) begin
        qclamp = INT_MAX;
      end
    end
    if (cmd_i.finish) begin
      if (dzero_q) begin
        res_d = INT_MAX;
      end else if (neg_q) begin
        res_d = ~qclamp + 1'b1;
      end else begin
        res_d = qclamp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dmag_q  <= dmag_d;
    neg_q   <= neg_d;
    dzero_q <= dzero_d;
    res_q   <= res_d;
  end

  assign quotient_o = res_q;

endmodule

`default_nettype wire

### design/sdiv_ctrl.sv
// Controller of the signed saturating divider: handshakes, iteration count
// and the output valid flag; drives the datapath through sdiv_cmd_t.
// Depends on sdiv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdiv_ctrl
  import sdiv_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire  logic out_ready_i,
  output sdiv_cmd_t  cmd_o
);

  sdiv_state_e          state_q, state_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                 ovalid_q, ovalid_d;
  logic                 out_free;

  // Output register can take a new word when empty or being drained
  assign out_free = !ovalid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
      end
      ST_FIN: begin
        cmd_o.finish = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Iteration counter: load on accept, count down while dividing
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_o.load) begin
      cnt_d = CNT_WIDTH'(DATA_WIDTH - 1);
    end else if (cmd_o.step) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Output valid: set on finish, drop when the word is taken
  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.finish) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

`default_nettype wire

### design/signed_int_divider_saturating.sv
// Signed saturating integer divider.
// Input stream carries {denominator, numerator}; output stream carries the
// quotient truncated toward zero and clamped to the signed 32-bit range.
// A zero denominator returns the largest positive value.
// Timing: a word is accepted only while the divider is idle (s_axis_tready
// high). The accept cycle loads the operand magnitudes, then ST_DIV runs one
// radix-2 restoring step per quotient bit on the shared subtractor, and ST_FIN
// applies sign and saturation into the output register. The quotient
// shows on m_axis_tvalid after ST_FIN, and with the output drained a new word
// can be accepted once the controller is back in idle.
// The output register holds one finished word; while it waits for
// m_axis_tready the next word may be accepted and divided, and its result
// waits in the final cycle until the register frees up.
// Reset (rst_ni low, asynchronous) returns the controller to idle and drops
// m_axis_tvalid; no other state needs clearing.
// Depends on sdiv_pkg, sdiv_ctrl and sdiv_dpath.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_divider_saturating
  import sdiv_pkg::*;
(
  input  wire  logic                    clk_i,
  input  wire  logic                    rst_ni,
  input  wire  logic                    s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire  logic [2*DATA_WIDTH-1:0] s_axis_tdata,  // [31:0] numerator, [63:32] denominator
  output logic                          m_axis_tvalid,
  input  wire  logic                    m_axis_tready,
  output logic [DATA_WIDTH-1:0]         m_axis_tdata   // [31:0] quotient
);

  sdiv_cmd_t cmd;

  sdiv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  sdiv_dpath u_dpath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .numerator_i   (s_axis_tdata[DATA_WIDTH-1:0]),
    .denominator_i (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .quotient_o    (m_axis_tdata)
  );

endmodule

`default_nettype wire

### design/sdiv_checker.sv
// Port-level checks for the signed saturating divider, bound to the top level.
// Depends on sdiv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdiv_checker
  import sdiv_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    s_axis_tvalid,
  input wire logic                    s_axis_tready,
  input wire logic                    m_axis_tvalid,
  input wire logic                    m_axis_tready,
  input wire logic [DATA_WIDTH-1:0]   m_axis_tdata
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed while stalled");

  // Busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after accept");

  // Still busy at the last division step
  a_busy_during_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> ##32 !s_axis_tready)
    else $error("input ready before division finished");

  // A new result only appears from the final cycle, never while idle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a division in progress");

endmodule

bind signed_int_divider_saturating sdiv_checker u_sdiv_checker (.*);

`default_nettype wire

### test/tb.sv
// Self-checking bench for signed_int_divider_saturating: streams operand pairs
// through the divider under several backpressure mixes and checks each quotient.
// Depends on sdiv_pkg and the divider RTL.
`timescale 1ns / 1ps

module tb;
  import sdiv_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;  // cycles without any accepted word
  localparam int unsigned RANDOM_PER_PHASE = 300;

  // One input word, packed to match s_axis_tdata
  typedef struct packed {
    logic [DATA_WIDTH-1:0] den;
    logic [DATA_WIDTH-1:0] num;
  } operands_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [2*DATA_WIDTH-1:0] s_axis_tdata = '0;  // [31:0] numerator, [63:32] denominator
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [DATA_WIDTH-1:0]   m_axis_tdata;       // [31:0] quotient

  operands_t               operand_q[$];
  logic [DATA_WIDTH-1:0]   quotient_q[$];
  int unsigned             sender_idle_pct = 0;
  int unsigned             receiver_stall_pct = 0;
  int unsigned             mismatches = 0;
  int unsigned             quiet_cycles = 0;

  signed_int_divider_saturating u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Quotient truncated toward zero, saturated; zero divisor gives INT_MAX
  function automatic logic [DATA_WIDTH-1:0] divide_saturate(input logic [DATA_WIDTH-1:0] num,
                                                            input logic [DATA_WIDTH-1:0] den);
    logic                  num_neg;
    logic                  den_neg;
    logic [DATA_WIDTH-1:0] num_mag;
    logic [DATA_WIDTH-1:0] den_mag;
    logic [DATA_WIDTH-1:0] q_mag;
    num_neg = num[DATA_WIDTH-1];
    den_neg = den[DATA_WIDTH-1];
    num_mag = num_neg ? -num : num;
    den_mag = den_neg ? -den : den;
    if (den_mag == '0) begin
      return INT_MAX;
    end
    q_mag = num_mag / den_mag;
    if (num_neg != den_neg) begin
      if (q_mag > INT_MIN) begin
        q_mag = INT_MIN;
      end
      return -q_mag;
    end
    if (q_mag > INT_MAX) begin
      return INT_MAX;
    end
    return q_mag;
  endfunction

  // Random operand, biased toward edges, small values and short magnitudes
  function automatic logic [DATA_WIDTH-1:0] pick_operand();
    logic [DATA_WIDTH-1:0] v;
    case ($urandom_range(9))
      0, 1: begin
        v = $urandom_range(200) - 100;
      end
      2: begin
        case ($urandom_range(4))
          0: v = INT_MIN;
          1: v = INT_MAX;
          2: v = '0;
          3: v = 1;
          default: v = '1;
        endcase
      end
      3, 4: begin
        v = $urandom >> $urandom_range(DATA_WIDTH - 1);
        if ($urandom_range(1) == 1) begin
          v = -v;
        end
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  task automatic queue_division(input logic [DATA_WIDTH-1:0] num,
                                input logic [DATA_WIDTH-1:0] den);
    operands_t op;
    op.num = num;
    op.den = den;
    operand_q.push_back(op);
  endtask

  // Drive operand words; predict the quotient of each accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        quotient_q.push_back(divide_saturate(s_axis_tdata[DATA_WIDTH-1:0],
                                             s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (operand_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= operand_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each accepted quotient word against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (quotient_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("tb: unexpected quotient word %h", m_axis_tdata);
          end
        end else begin
          if (m_axis_tdata !== quotient_q[0]) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("tb: quotient mismatch, expected %h actual %h",
                       quotient_q[0], m_axis_tdata);
            end
          end
          void'(quotient_q.pop_front());
        end
      end
    end
  end

  // Abort when work is outstanding but no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (operand_q.size() == 0 && !s_axis_tvalid && quotient_q.size() == 0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned phase;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
        default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
      endcase

      if (phase == 0) begin
        // zero divisor, with zero and extreme dividends
        queue_division('0, '0);
        queue_division(INT_MIN, '0);
        queue_division(INT_MAX, '0);
        queue_division('1, '0);
        // most negative over minus one saturates, plus other extreme operand pairs
        queue_division(INT_MIN, '1);
        queue_division(INT_MIN, 1);
        queue_division(INT_MAX, '1);
        queue_division(INT_MAX, INT_MIN);
        queue_division(INT_MIN, INT_MIN);
        queue_division(INT_MIN, INT_MAX);
        queue_division(INT_MAX, 1);
        queue_division(INT_MIN, 2);
        queue_division('1, INT_MIN);
        // all four sign combinations, truncation toward zero
        queue_division(7, 2);
        queue_division(-32'sd7, 2);
        queue_division(7, -32'sd2);
        queue_division(-32'sd7, -32'sd2);
        // dividend magnitude not above divisor magnitude, then a large dividend over minus three
        queue_division(3, 5);
        queue_division(-32'sd3, 5);
        queue_division(1, '1);
        queue_division('0, -32'sd5);
        queue_division(32'd12345678, -32'sd3);
      end
      repeat (RANDOM_PER_PHASE) begin
        queue_division(pick_operand(), pick_operand());
      end

      // drain everything before changing the backpressure mix
      while (operand_q.size() != 0 || s_axis_tvalid || quotient_q.size() != 0) begin
        @(negedge clk_i);
      end
    end

    // let any stray output word show up
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && quotient_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
